// ===== hdl/modexp_pkg.sv =====
package modexp_pkg;

  localparam int unsigned FieldWidth = 32;

  typedef struct packed {
    logic [FieldWidth-1:0] base_value;
    logic [FieldWidth-1:0] power;
    logic [FieldWidth-1:0] modulus;
  } in_t;

  typedef struct packed {
    logic [FieldWidth-1:0] residue;
    logic                  modulus_zero;
  } out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_RED_WB,
    ST_CHECK,
    ST_MUL_ACC,
    ST_ACC_WB,
    ST_MUL_SQ,
    ST_SQ_WB,
    ST_DONE
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic step;
    logic start_acc;
    logic start_sq;
    logic wr_acc;
    logic wr_sq;
    logic shift_e;
    logic out_load;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic m_zero;
    logic e_zero;
    logic e_lsb;
    logic last;
  } status_t;

endpackage

// ===== hdl/modexp_dp.sv =====
module modexp_dp import modexp_pkg::*; #(
  parameter int unsigned OperandWidth = 32
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cmd_t    cmd_i,
  input  in_t     in_data_i,
  output status_t status_o,
  output out_t    out_data_o
);

  localparam int unsigned W    = OperandWidth;
  localparam int unsigned CntW = $clog2(W);

  logic [W-1:0]    m_q, e_q, acc_q, sq_q, p_q, a_q, mul_q;
  logic [CntW-1:0] cnt_q;
  out_t            out_q;

  // operands taken modulo 2^W
  logic [W+FieldWidth-1:0] base_ext, pow_ext, mod_ext, res_ext;
  logic [W-1:0]            base_op, pow_op, mod_op;

  assign base_ext = {{W{1'b0}}, in_data_i.base_value};
  assign pow_ext  = {{W{1'b0}}, in_data_i.power};
  assign mod_ext  = {{W{1'b0}}, in_data_i.modulus};
  assign base_op  = base_ext[W-1:0];
  assign pow_op   = pow_ext[W-1:0];
  assign mod_op   = mod_ext[W-1:0];
  assign res_ext  = {{FieldWidth{1'b0}}, acc_q};

  // one shift-and-add step: p = (2p + bit*a) mod m, each half reduced once
  logic [W:0]   dbl, dbl_sub, sum, sum_sub;
  logic [W-1:0] dbl_r, addend, step_p;

  always_comb begin
    dbl     = {p_q, 1'b0};
    dbl_sub = dbl - {1'b0, m_q};
    dbl_r   = (dbl >= {1'b0, m_q}) ? dbl_sub[W-1:0] : dbl[W-1:0];
    addend  = mul_q[W-1] ? a_q : '0;
    sum     = {1'b0, dbl_r} + {1'b0, addend};
    sum_sub = sum - {1'b0, m_q};
    step_p  = (sum >= {1'b0, m_q}) ? sum_sub[W-1:0] : sum[W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.load || cmd_i.start_acc || cmd_i.start_sq) begin
      cnt_q <= '0;
    end else if (cmd_i.step) begin
      cnt_q <= cnt_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      m_q   <= mod_op;
      e_q   <= pow_op;
      acc_q <= {{(W-1){1'b0}}, (mod_op != W'(1))};
      p_q   <= '0;
      a_q   <= W'(1);
      mul_q <= base_op;
    end
    if (cmd_i.step) begin
      p_q   <= step_p;
      mul_q <= {mul_q[W-2:0], 1'b0};
    end
    if (cmd_i.start_acc) begin
      p_q   <= '0;
      a_q   <= acc_q;
      mul_q <= sq_q;
    end
    if (cmd_i.start_sq) begin
      p_q   <= '0;
      a_q   <= sq_q;
      mul_q <= sq_q;
    end
    if (cmd_i.wr_acc) begin
      acc_q <= p_q;
    end
    if (cmd_i.wr_sq) begin
      sq_q <= p_q;
    end
    if (cmd_i.shift_e) begin
      e_q <= e_q >> 1;
    end
    if (cmd_i.out_load) begin
      out_q.residue      <= (m_q == '0) ? '0 : res_ext[FieldWidth-1:0];
      out_q.modulus_zero <= (m_q == '0);
    end
  end

  assign status_o.m_zero = (m_q == '0);
  assign status_o.e_zero = (e_q == '0);
  assign status_o.e_lsb  = e_q[0];
  assign status_o.last   = (cnt_q == CntW'(W - 1));
  assign out_data_o      = out_q;

endmodule

// ===== hdl/modexp_ctrl.sv =====
module modexp_ctrl import modexp_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:    if (in_valid_i) state_d = ST_REDUCE;
      ST_REDUCE: begin
        if (status_i.m_zero)    state_d = ST_DONE;
        else if (status_i.last) state_d = ST_RED_WB;
      end
      ST_RED_WB:  state_d = ST_CHECK;
      ST_CHECK: begin
        if (status_i.e_zero)     state_d = ST_DONE;
        else if (status_i.e_lsb) state_d = ST_MUL_ACC;
        else                     state_d = ST_MUL_SQ;
      end
      ST_MUL_ACC: if (status_i.last) state_d = ST_ACC_WB;
      ST_ACC_WB:  state_d = ST_MUL_SQ;
      ST_MUL_SQ:  if (status_i.last) state_d = ST_SQ_WB;
      ST_SQ_WB:   state_d = ST_CHECK;
      ST_DONE:    if (out_free) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_REDUCE:  cmd_o.step = !status_i.m_zero;
      ST_RED_WB:  cmd_o.wr_sq = 1'b1;
      ST_CHECK: begin
        cmd_o.start_acc = !status_i.e_zero && status_i.e_lsb;
        cmd_o.start_sq  = !status_i.e_zero && !status_i.e_lsb;
      end
      ST_MUL_ACC: cmd_o.step = 1'b1;
      ST_ACC_WB: begin
        cmd_o.wr_acc   = 1'b1;
        cmd_o.start_sq = 1'b1;
      end
      ST_MUL_SQ:  cmd_o.step = 1'b1;
      ST_SQ_WB: begin
        cmd_o.wr_sq   = 1'b1;
        cmd_o.shift_e = 1'b1;
      end
      ST_DONE:    cmd_o.out_load = out_free;
      default:    cmd_o = '0;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load)  out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== hdl/modular_exponentiation.sv =====
// Modular exponentiation: residue = base_value ** power mod modulus.
// Input channel in_valid_i/in_ready_o carries one transaction {base_value, power,
// modulus}; output channel out_valid_o/out_ready_i returns {residue, modulus_zero}.
// One transaction is processed at a time; in_ready_o is high only while idle.
// From the accepting edge the block first reduces the base; then, for each
// exponent bit up to the highest set one, it checks the bit and squares, and
// when the bit is set it first multiplies into the accumulator; a last check
// and the output load follow. A zero exponent goes from the reduction straight
// to the last check. Every product comes from the shared shift-and-add modular
// multiplier, which retires one multiplier bit per cycle.
// A zero modulus skips the reduction and the exponent bits and ends the
// transaction with modulus_zero = 1, residue 0.
// The result sits in an output register and the next transaction is accepted
// the cycle after it is loaded. While the receiver stalls the block holds it,
// computes the next result and then waits to load it until the held result
// is taken; only then does it go idle again.
// Reset clears the controller and drops any result not yet taken.
module modular_exponentiation import modexp_pkg::*; #(
  parameter int unsigned OPERAND_WIDTH = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  cmd_t    cmd;
  status_t status;

  modexp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  modexp_dp #(
    .OperandWidth(OPERAND_WIDTH)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .in_data_i (in_data_i),
    .status_o  (status),
    .out_data_o(out_data_o)
  );

  a_err_zero_residue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.modulus_zero |-> out_data_o.residue == '0)
    else $error("residue not zero on modulus error");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second transaction taken while busy");

  a_result_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result raised straight from idle");

  a_single_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.load, cmd.step, cmd.start_acc, cmd.start_sq}))
    else $error("conflicting product commands");

endmodule
